// File: hw/rtl/indexed_lru_list_defines.svh
// Assertion macros for the indexed LRU list checker.
// No dependencies; included by the checker file only.
`ifndef INDEXED_LRU_LIST_DEFINES_SVH
`define INDEXED_LRU_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ILL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_lru_list: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ILL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_lru_list: next-cycle check failed");

`endif

// File: hw/rtl/idxlru_pkg.sv
// Shared types and codes for the indexed LRU list.
// No dependencies; used by every other file of the block but the defines header.
package idxlru_pkg;

    localparam int IDX_W = 6;
    localparam int ACT_W = 3;

    // Action codes; 5..7 are unused and change nothing.
    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_HEAD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_TAIL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] entry_index;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] popped_entry;
        logic             popped_valid;
        logic             was_present;
        logic             now_empty;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic exec;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

// File: hw/rtl/idxlru_ctrl.sv
// Controller FSM for the indexed LRU list: clearing pass, accept, execute.
// Depends on idxlru_pkg.
module idxlru_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  idxlru_pkg::status_t  status,
    output idxlru_pkg::cmd_t     cmd
);

    idxlru_pkg::state_t state_reg;
    idxlru_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idxlru_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            idxlru_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = idxlru_pkg::ST_IDLE;
                end
            end
            idxlru_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = idxlru_pkg::ST_EXEC;
                end
            end
            idxlru_pkg::ST_EXEC:
            begin
                state_next = idxlru_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = idxlru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            idxlru_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            idxlru_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            idxlru_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hw/rtl/idxlru_dp.sv
// Datapath for the indexed LRU list: link and flag memories, head/tail/empty
// registers, clear counter and result register. Depends on idxlru_pkg.
module idxlru_dp #(
    parameter int ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  idxlru_pkg::item_t    item,
    input  idxlru_pkg::cmd_t     cmd,
    output idxlru_pkg::status_t  status,
    output idxlru_pkg::result_t  result,
    output logic                 done
);

    localparam int SW = $clog2(ENTRIES);

    // Memories
    logic [SW-1:0] next_mem [ENTRIES];
    logic [SW-1:0] prev_mem [ENTRIES];
    logic          flag_mem [ENTRIES];

    // Control registers
    logic [SW-1:0] head_reg,  head_next;
    logic [SW-1:0] tail_reg,  tail_next;
    logic          empty_reg, empty_next;
    logic [SW-1:0] clr_cnt_reg;
    logic          done_reg;

    // Captured item and read data
    logic [idxlru_pkg::ACT_W-1:0] act_reg;
    logic [SW-1:0]                slot_reg;
    logic                         in_range_reg;
    logic [SW-1:0]                next_rd_reg;
    logic [SW-1:0]                prev_rd_reg;
    logic                         flag_rd_reg;
    idxlru_pkg::result_t          out_reg, out_next;

    // Load-side address
    logic [SW-1:0] rd_addr;
    logic          in_range;

    // Write ports
    logic          next_we, prev_we, flag_we;
    logic [SW-1:0] next_wa, next_wd, prev_wa, prev_wd, flag_wa;
    logic          flag_wd;

    // Execute decode
    logic is_insert, is_pop, is_remove;
    logic do_link, do_unlink, is_head, is_tail;

    assign in_range = ({26'd0, item.entry_index} < 32'(ENTRIES));

    always_comb
    begin
        unique case (item.action)
            idxlru_pkg::ACT_POP_HEAD: rd_addr = head_reg;
            idxlru_pkg::ACT_POP_TAIL: rd_addr = tail_reg;
            default:                  rd_addr = SW'(item.entry_index);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg      <= item.action;
            slot_reg     <= rd_addr;
            in_range_reg <= in_range;
        end
    end

    // Link memories, registered read at load time
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (cmd.load)
        begin
            next_rd_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (cmd.load)
        begin
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
        if (cmd.load)
        begin
            flag_rd_reg <= flag_mem[rd_addr];
        end
    end

    always_comb
    begin
        is_insert = (act_reg == idxlru_pkg::ACT_INS_HEAD) ||
                    (act_reg == idxlru_pkg::ACT_INS_TAIL);
        is_pop    = (act_reg == idxlru_pkg::ACT_POP_HEAD) ||
                    (act_reg == idxlru_pkg::ACT_POP_TAIL);
        is_remove = (act_reg == idxlru_pkg::ACT_REMOVE);
        do_link   = cmd.exec && is_insert && in_range_reg && !flag_rd_reg;
        do_unlink = cmd.exec && ((is_remove && in_range_reg && flag_rd_reg) ||
                                 (is_pop && !empty_reg));
        is_head   = (head_reg == slot_reg);
        is_tail   = (tail_reg == slot_reg);

        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        next_we = 1'b0;
        next_wa = slot_reg;
        next_wd = head_reg;
        prev_we = 1'b0;
        prev_wa = slot_reg;
        prev_wd = tail_reg;
        flag_we = 1'b0;
        flag_wa = slot_reg;
        flag_wd = 1'b0;

        if (cmd.clear_en)
        begin
            flag_we = 1'b1;
            flag_wa = clr_cnt_reg;
        end

        if (do_link)
        begin
            flag_we = 1'b1;
            flag_wd = 1'b1;
            if (empty_reg)
            begin
                head_next  = slot_reg;
                tail_next  = slot_reg;
                empty_next = 1'b0;
            end
            else if (act_reg == idxlru_pkg::ACT_INS_HEAD)
            begin
                next_we   = 1'b1;
                next_wa   = slot_reg;
                next_wd   = head_reg;
                prev_we   = 1'b1;
                prev_wa   = head_reg;
                prev_wd   = slot_reg;
                head_next = slot_reg;
            end
            else
            begin
                prev_we   = 1'b1;
                prev_wa   = slot_reg;
                prev_wd   = tail_reg;
                next_we   = 1'b1;
                next_wa   = tail_reg;
                next_wd   = slot_reg;
                tail_next = slot_reg;
            end
        end

        if (do_unlink)
        begin
            flag_we = 1'b1;
            flag_wd = 1'b0;
            if (is_head && is_tail)
            begin
                empty_next = 1'b1;
                head_next  = '0;
                tail_next  = '0;
            end
            else
            begin
                if (is_head)
                begin
                    head_next = next_rd_reg;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd_reg;
                    next_wd = next_rd_reg;
                end
                if (is_tail)
                begin
                    tail_next = prev_rd_reg;
                end
                else
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd_reg;
                    prev_wd = prev_rd_reg;
                end
            end
        end

        out_next.popped_valid = is_pop && !empty_reg;
        out_next.popped_entry = out_next.popped_valid ? idxlru_pkg::IDX_W'(slot_reg) : '0;
        out_next.was_present  = is_pop ? !empty_reg
                                       : ((is_insert || is_remove) && in_range_reg &&
                                          flag_rd_reg);
        out_next.now_empty    = empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            done_reg  <= cmd.exec;
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_reg <= out_next;
        end
    end

    assign status.clear_last = cmd.clear_en && (clr_cnt_reg == SW'(ENTRIES - 1));
    assign result = out_reg;
    assign done   = done_reg;

endmodule

// File: hw/rtl/indexed_lru_list.sv
// Top level of the indexed LRU list: controller plus datapath.
// Depends on idxlru_pkg, idxlru_ctrl and idxlru_dp.
//
// Usage:
//   Input channel: drive item (action, entry_index) and raise start. The word
//   is taken at a rising edge where start is high and busy is low.
//   Output channel: done pulses for exactly one cycle with result valid in
//   that same cycle; the receiver must take it then, it cannot stall.
//   The accepting edge reads the slot's flag and neighbor links from the
//   memories into registers; the execute state writes the updated links,
//   flag and head/tail and loads the result. busy is high in the execute
//   state, so no new word is taken before the last is done; busy is low
//   again in the done cycle, so the next word may be accepted right then.
//   Reset: rst_n clears head and tail and sets the empty flag at once, then
//   the block runs a clearing pass over the membership flags, one slot per
//   cycle, with busy held high. Link memories are not cleared; a link is
//   only used for a slot that is in the list.
//   Unused action codes and slot numbers at or beyond ENTRIES change nothing.
module indexed_lru_list #(
    parameter int ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  idxlru_pkg::item_t    item,
    output idxlru_pkg::result_t  result,
    output logic                 done
);

    idxlru_pkg::cmd_t    cmd;
    idxlru_pkg::status_t status;

    // FSM: clear pass, idle/accept, execute
    idxlru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Memories, list registers and result register
    idxlru_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .done   (done)
    );

endmodule

// File: hw/rtl/idxlru_checker.sv
// Port-level checker for the indexed LRU list, bound to the top level.
// Depends on idxlru_pkg and indexed_lru_list_defines.svh.
`include "indexed_lru_list_defines.svh"

module idxlru_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input idxlru_pkg::result_t  result,
    input logic                 done
);

    // An accepted word makes the block busy, and the answer comes in the cycle after that.
    `ILL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `ILL_ASSERT_NEXT(a_accept_done, start && !busy, ##1 done)
    // The answer cycle is also a cycle where a new word can be taken.
    `ILL_ASSERT_NOW(a_done_idle, done, !busy)
    // A valid pop is always a present slot; any other result reports slot zero.
    `ILL_ASSERT_NOW(a_pop_present, done && result.popped_valid,
                    result.was_present && !(result.now_empty && !result.was_present))
    `ILL_ASSERT_NOW(a_nopop_zero, done && !result.popped_valid,
                    result.popped_entry == '0)

endmodule

bind indexed_lru_list idxlru_checker u_idxlru_checker (.*);

// File: tb/testbench.sv
// Self-checking bench for indexed_lru_list: directed and random list actions
// against an in-bench linked-list predictor. Depends on idxlru_pkg and the RTL.
module testbench;
    import idxlru_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int STALL_LIMIT = 2000;  // cycles with no word moving in either direction
    localparam int SETTLE      = 4;     // slack after the last result returns
    localparam int MAX_PRINTS  = 40;

    // Action codes the block does not use; they must change nothing.
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    indexed_lru_list #(.ENTRIES(ENTRIES)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .done   (done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the list. Links start at zero; only
    // members' links are ever followed, so their start value never shows.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] next_of [ENTRIES];
    logic [IDX_W-1:0] prev_of [ENTRIES];
    bit               in_list [ENTRIES];
    logic [IDX_W-1:0] head_slot;
    logic [IDX_W-1:0] tail_slot;
    bit               list_empty;
    int               depth;

    result_t pending_results[$];  // predicted results, oldest first

    // Run statistics, for the summary and the final verdict.
    int errors;
    int words_sent;
    int results_seen;
    int pops_hit;
    int removes_hit;
    int deepest;
    int burst_left;

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            next_of[i] = '0;
            prev_of[i] = '0;
            in_list[i] = 1'b0;
        end
        head_slot    = '0;
        tail_slot    = '0;
        list_empty   = 1'b1;
        depth        = 0;
        errors       = 0;
        words_sent   = 0;
        results_seen = 0;
        pops_hit     = 0;
        removes_hit  = 0;
        deepest      = 0;
        burst_left   = 0;
    end

    // Take slot s out of the list, patching its neighbors or head/tail.
    function automatic void unlink_slot(logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] n;
        p = prev_of[s];
        n = next_of[s];
        if (head_slot == s && tail_slot == s)
        begin
            // last member leaves: list goes empty, ends park at zero
            list_empty = 1'b1;
            head_slot  = '0;
            tail_slot  = '0;
        end
        else
        begin
            if (head_slot == s)
                head_slot = n;
            else
                next_of[p] = n;
            if (tail_slot == s)
                tail_slot = p;
            else
                prev_of[n] = p;
        end
        in_list[s] = 1'b0;
        depth--;
    endfunction

    // Apply one word to the mirror and return the result the block owes.
    function automatic result_t apply_action(item_t w);
        result_t          r;
        logic [IDX_W-1:0] s;
        r = '0;
        s = w.entry_index;
        case (w.action)
            ACT_INS_HEAD, ACT_INS_TAIL:
            begin
                if (int'(s) < ENTRIES)
                begin
                    r.was_present = in_list[s];
                    if (!in_list[s])
                    begin
                        if (list_empty)
                        begin
                            head_slot  = s;
                            tail_slot  = s;
                            list_empty = 1'b0;
                        end
                        else if (w.action == ACT_INS_HEAD)
                        begin
                            next_of[s]         = head_slot;
                            prev_of[head_slot] = s;
                            head_slot          = s;
                        end
                        else
                        begin
                            prev_of[s]         = tail_slot;
                            next_of[tail_slot] = s;
                            tail_slot          = s;
                        end
                        in_list[s] = 1'b1;
                        depth++;
                        if (depth > deepest)
                            deepest = depth;
                    end
                end
            end
            ACT_REMOVE:
            begin
                if (int'(s) < ENTRIES)
                begin
                    r.was_present = in_list[s];
                    if (in_list[s])
                    begin
                        unlink_slot(s);
                        removes_hit++;
                    end
                end
            end
            ACT_POP_HEAD, ACT_POP_TAIL:
            begin
                // pops ignore entry_index; an empty list gives zeros with now_empty set
                if (!list_empty)
                begin
                    s = (w.action == ACT_POP_HEAD) ? head_slot : tail_slot;
                    r.popped_entry = s;
                    r.popped_valid = 1'b1;
                    r.was_present  = 1'b1;
                    unlink_slot(s);
                    pops_hit++;
                end
            end
            default: ;  // spare codes: no state change
        endcase
        r.now_empty = list_empty;
        return r;
    endfunction

    function automatic item_t make_word(logic [ACT_W-1:0] a, logic [IDX_W-1:0] idx);
        item_t w;
        w.action      = a;
        w.entry_index = idx;
        return w;
    endfunction

    // Some current member, found by scanning from a random slot.
    function automatic logic [IDX_W-1:0] random_member();
        int first;
        first = $urandom_range(ENTRIES - 1);
        for (int k = 0; k < ENTRIES; k++)
            if (in_list[(first + k) % ENTRIES])
                return IDX_W'((first + k) % ENTRIES);
        return IDX_W'(first);
    endfunction

    // ------------------------------------------------------------------
    // Sender. start stays high across back-to-back words; it is only
    // lowered when a burst ends or a test hands over, so start never sees
    // two assignments in one time step.
    // ------------------------------------------------------------------
    task automatic send_word(item_t w);
        item  <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        // accepted at this edge: predict now
        pending_results.push_back(apply_action(w));
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 9);
        end
    endtask

    // Hold off until every predicted result has come back, then settle.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch %0d at %0t: %s got %0d want %0d",
                     errors, $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe and cannot be stalled,
    // so every strobed cycle is a result taken at that edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, popped_entry",
                                result.popped_entry, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.popped_entry !== want.popped_entry)
                    report_mismatch("popped_entry", result.popped_entry,
                                    want.popped_entry);
                if (result.popped_valid !== want.popped_valid)
                    report_mismatch("popped_valid", result.popped_valid,
                                    want.popped_valid);
                if (result.was_present !== want.was_present)
                    report_mismatch("was_present", result.was_present,
                                    want.was_present);
                if (result.now_empty !== want.now_empty)
                    report_mismatch("now_empty", result.now_empty, want.now_empty);
            end
        end
    end

    // Watchdog: any long stretch with no word taken and no result ends the run.
    // The clearing pass after reset fits well inside the limit.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no activity for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every action against an empty list: pops return nothing, a remove
    // finds nothing, spare codes leave the list alone.
    task automatic test_empty_list();
        send_word(make_word(ACT_POP_HEAD, 6'd63));
        send_word(make_word(ACT_POP_TAIL, 6'd0));
        send_word(make_word(ACT_REMOVE, 6'd63));
        send_word(make_word(ACT_REMOVE, 6'd0));
        send_word(make_word(ACT_SPARE_FIRST, 6'd63));
        send_word(make_word(ACT_SPARE_LAST, 6'd0));
        wait_results_drained();
    endtask

    // Extreme slots, inserts of members already present, removal at the
    // head, tail and middle, and going back to empty by pop from each end.
    task automatic test_end_slots();
        send_word(make_word(ACT_INS_HEAD, 6'd0));
        send_word(make_word(ACT_INS_TAIL, 6'd63));
        send_word(make_word(ACT_INS_HEAD, 6'd63));   // already present
        send_word(make_word(ACT_INS_TAIL, 6'd0));    // already present
        send_word(make_word(ACT_INS_HEAD, 6'd42));
        send_word(make_word(ACT_INS_TAIL, 6'd21));
        send_word(make_word(ACT_SPARE_MID, 6'd42));  // spare code, list not empty
        send_word(make_word(ACT_REMOVE, 6'd0));      // middle member
        send_word(make_word(ACT_REMOVE, 6'd42));     // head
        send_word(make_word(ACT_REMOVE, 6'd21));     // tail
        send_word(make_word(ACT_POP_HEAD, 6'd5));    // last member
        send_word(make_word(ACT_INS_TAIL, 6'd5));
        send_word(make_word(ACT_POP_TAIL, 6'd63));   // single member from tail
        send_word(make_word(ACT_INS_HEAD, 6'd7));
        send_word(make_word(ACT_INS_HEAD, 6'd9));
        send_word(make_word(ACT_POP_TAIL, 6'd0));
        send_word(make_word(ACT_POP_HEAD, 6'd0));
        wait_results_drained();
    endtask

    // Random actions; grow_pct is the share of inserts, which steers the
    // list toward full or toward empty. Removes mostly name a member.
    task automatic test_random_mix(int n_words, int grow_pct);
        int               roll;
        logic [ACT_W-1:0] a;
        logic [IDX_W-1:0] idx;
        for (int i = 0; i < n_words; i++)
        begin
            roll = $urandom_range(99);
            idx  = IDX_W'($urandom_range(ENTRIES - 1));
            if (roll < 3)
                a = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            else if (roll < 3 + grow_pct)
                a = $urandom_range(1) ? ACT_INS_HEAD : ACT_INS_TAIL;
            else
            begin
                case ($urandom_range(2))
                    0:       a = ACT_POP_HEAD;
                    1:       a = ACT_POP_TAIL;
                    default:
                    begin
                        a = ACT_REMOVE;
                        if (depth > 0 && $urandom_range(9) < 7)
                            idx = random_member();
                    end
                endcase
            end
            send_word(make_word(a, idx));
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass holds busy high; send_word waits it out

        test_empty_list();
        test_end_slots();
        test_random_mix(120, 70);  // fill up
        test_random_mix(120, 25);  // drain down
        test_random_mix(180, 45);  // steady churn
        test_random_mix(90, 85);   // push toward full
        test_random_mix(90, 10);   // back toward empty

        if (pending_results.size() != 0)
            report_mismatch("results never returned", 0, pending_results.size());

        $display("run covered %0d words and %0d results: %0d pops returned a slot,",
                 words_sent, results_seen, pops_hit);
        $display("%0d removes hit a member, list grew to %0d of %0d slots",
                 removes_hit, deepest, ENTRIES);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
